// ===== hw/rtl/motion_detector_i2c_target_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motion detector
// Concurrent checks clocked on clk; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MOTION_DETECTOR_I2C_TARGET_ASSERT_SVH
`define MOTION_DETECTOR_I2C_TARGET_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that holds outside reset.
`define MDI2C_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that holds during reset as well.
`define MDI2C_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MDI2C_ASSERT(lbl, prop, msg)
`define MDI2C_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/mdi2c_pkg.sv =====
// ----------------------------------------------------------------------------
// mdi2c_pkg
// Types and constants shared by the motion detector and its bus target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdi2c_pkg;

	// item operations
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_EVENT  = 2'd2
	} op_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_ADDR = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT     = 1'd1;

	localparam logic [6:0] ADDR_RESET    = 7'd72;
	localparam logic [5:0] TIMEOUT_RESET = 6'd32;
	localparam logic [7:0] THRESH_RESET  = 8'd50;
	localparam logic [5:0] CODE_MASK     = 6'h33;

	localparam logic [7:0] ACK_BYTE  = 8'h00;
	localparam logic [7:0] NACK_BYTE = 8'hFF;

	// bit counts handed to the byte shifter
	localparam logic [3:0] CNT_NONE = 4'd0;
	localparam logic [3:0] CNT_ACK  = 4'd1;
	localparam logic [3:0] CNT_BYTE = 4'd8;

	// bus object numbers
	localparam logic [7:0] OBJ_INTERVAL  = 8'd2;
	localparam logic [7:0] OBJ_THRESHOLD = 8'd3;

	// bus target state machine
	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_RX_ADDR  = 12'b0000_0000_0010,
		ST_CHK_ADDR = 12'b0000_0000_0100,
		ST_WAIT     = 12'b0000_0000_1000,
		ST_RX_OBJ   = 12'b0000_0001_0000,
		ST_ACK_OBJ  = 12'b0000_0010_0000,
		ST_RX_VAL   = 12'b0000_0100_0000,
		ST_ACK_VAL  = 12'b0000_1000_0000,
		ST_APPLY    = 12'b0001_0000_0000,
		ST_TX_DATA  = 12'b0010_0000_0000,
		ST_RX_ACK   = 12'b0100_0000_0000,
		ST_CHK_ACK  = 12'b1000_0000_0000
	} bus_state_t;

	// what one shifter event asks of the outside
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic [3:0] count;
		logic       upd;
		logic [5:0] code;
		logic       sda;
	} bus_res_t;

	// one result item
	typedef struct packed {
		logic       start_conversion;
		logic       led_level;
		logic       motion_pulse;
		logic       interval_update;
		logic [5:0] interval_code;
		logic       sda_drive;
		logic       load_shift;
		logic [7:0] shift_data;
		logic [3:0] shift_count;
	} res_t;

endpackage

// ===== hw/rtl/mdi2c_if.sv =====
// ----------------------------------------------------------------------------
// mdi2c_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mdi2c_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] sample_value;
	logic        start_seen;
	logic [7:0]  shift_byte;

	modport source (output valid, operation, sample_value, start_seen, shift_byte,
		input ready);
	modport sink (input valid, operation, sample_value, start_seen, shift_byte,
		output ready);
endinterface

interface mdi2c_out_if;
	logic       valid;
	logic       ready;
	logic       start_conversion;
	logic       led_level;
	logic       motion_pulse;
	logic       interval_update;
	logic [5:0] interval_code;
	logic       sda_drive;
	logic       load_shift;
	logic [7:0] shift_data;
	logic [3:0] shift_count;

	modport source (output valid, start_conversion, led_level, motion_pulse,
		interval_update, interval_code, sda_drive, load_shift, shift_data, shift_count,
		input ready);
	modport sink (input valid, start_conversion, led_level, motion_pulse,
		interval_update, interval_code, sda_drive, load_shift, shift_data, shift_count,
		output ready);
endinterface

// ===== hw/rtl/motion_detector_i2c_target.sv =====
// ----------------------------------------------------------------------------
// motion_detector_i2c_target
// Motion sensor core with a bus target for threshold/interval setup and reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: an interval tick, a converter sample
//   or a byte-shifter event, selected by operation. out_ch returns exactly one
//   result item for each input item, in order.
//   cfg_we/cfg_index/cfg_wdata write target_address (0) and
//   motion_timeout_code (1); write only while no item is in flight.
// Timing:
//   An accepted item lands in an input register; its result is computed from
//   there and captured in the output register once that register is empty or
//   being taken, and is held there until out_ch takes it.
//   One item per cycle is sustained while out_ch does not stall.
// Stall:
//   While out_ch is stalled, one more item is taken into the input register,
//   then in_ch.ready drops until the output register is emptied.
// Reset:
//   arst_n clears the LED, motion flag, previous sample and the bus machine
//   (idle), and loads threshold 50, address 72 and timeout code 32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "motion_detector_i2c_target_assert.svh"

module motion_detector_i2c_target #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mdi2c_in_if.sink                            in_ch,
	mdi2c_out_if.source                         out_ch,
	input  logic                                cfg_we,
	input  logic [mdi2c_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [6:0]                          cfg_wdata
);

	// configuration
	logic [6:0] target_address_q;
	logic [5:0] timeout_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= mdi2c_pkg::ADDR_RESET;
			timeout_code_q   <= mdi2c_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mdi2c_pkg::REG_TARGET_ADDR: target_address_q <= cfg_wdata;
				mdi2c_pkg::REG_TIMEOUT:     timeout_code_q   <= cfg_wdata[5:0];
				default: begin
				end
			endcase
		end
	end

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] sample_s1;
	logic        start_s1;
	logic [7:0]  sb_s1;
	logic        advance;
	logic        out_valid_q;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_s1     <= in_ch.operation;
			sample_s1 <= in_ch.sample_value;
			start_s1  <= in_ch.start_seen;
			sb_s1     <= in_ch.shift_byte;
		end
	end

	// sensor state
	logic                   led_q, led_nxt;
	logic                   motion_q, motion_nxt;
	logic [SAMPLE_BITS-1:0] prev_q, prev_nxt;

	// bus target
	mdi2c_pkg::bus_res_t bus_res;
	logic                bus_step;
	logic                sda_level;
	logic [7:0]          threshold;

	assign bus_step = advance && (op_s1 == mdi2c_pkg::OP_EVENT);

	mdi2c_target u_target (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (bus_step),
		.start_seen     (start_s1),
		.shift_byte     (sb_s1),
		.target_address (target_address_q),
		.motion_flag    (motion_q),
		.res            (bus_res),
		.sda_level      (sda_level),
		.threshold      (threshold)
	);

	// sample compare
	logic [SAMPLE_BITS-1:0] samp;
	logic [SAMPLE_BITS-1:0] diff;
	logic                   moved;

	assign samp  = SAMPLE_BITS'(sample_s1);
	assign diff  = (samp > prev_q) ? (samp - prev_q) : (prev_q - samp);
	assign moved = diff > SAMPLE_BITS'(threshold);

	mdi2c_pkg::res_t res, res_q;

	always_comb begin
		led_nxt    = led_q;
		motion_nxt = motion_q;
		prev_nxt   = prev_q;
		res        = '0;
		res.sda_drive = sda_level;
		unique case (op_s1)
			mdi2c_pkg::OP_TICK: begin
				// dark LED: ask for a conversion; lit LED: timeout expired
				res.start_conversion = !led_q;
				led_nxt              = 1'b0;
			end
			mdi2c_pkg::OP_SAMPLE: begin
				prev_nxt   = samp;
				motion_nxt = moved;
				if (moved) begin
					led_nxt             = 1'b1;
					res.motion_pulse    = 1'b1;
					res.interval_update = 1'b1;
					res.interval_code   = timeout_code_q & mdi2c_pkg::CODE_MASK;
				end
			end
			mdi2c_pkg::OP_EVENT: begin
				if (start_s1) begin
					led_nxt = 1'b1;
				end
				res.interval_update = bus_res.upd;
				res.interval_code   = bus_res.code;
				res.sda_drive       = bus_res.sda;
				res.load_shift      = bus_res.load;
				res.shift_data      = bus_res.load ? bus_res.data : 8'd0;
				res.shift_count     = bus_res.count;
			end
			default: begin
			end
		endcase
		res.led_level = led_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q    <= 1'b0;
			motion_q <= 1'b0;
			prev_q   <= '0;
		end else if (advance) begin
			led_q    <= led_nxt;
			motion_q <= motion_nxt;
			prev_q   <= prev_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.start_conversion = res_q.start_conversion;
	assign out_ch.led_level        = res_q.led_level;
	assign out_ch.motion_pulse     = res_q.motion_pulse;
	assign out_ch.interval_update  = res_q.interval_update;
	assign out_ch.interval_code    = res_q.interval_code;
	assign out_ch.sda_drive        = res_q.sda_drive;
	assign out_ch.load_shift       = res_q.load_shift;
	assign out_ch.shift_data       = res_q.shift_data;
	assign out_ch.shift_count      = res_q.shift_count;

	// checks
	`MDI2C_ASSERT(a_adv_fills_out, advance |=> out_valid_q, "item lost between stages")
	`MDI2C_ASSERT(a_pulse_lights_led,
		out_valid_q && res_q.motion_pulse |-> res_q.led_level, "motion without LED")
	`MDI2C_ASSERT(a_no_load_no_data,
		out_valid_q && !res_q.load_shift |-> res_q.shift_data == 8'd0, "stray shift data")
	`MDI2C_ASSERT(a_no_upd_no_code,
		out_valid_q && !res_q.interval_update |-> res_q.interval_code == 6'd0,
		"stray interval code")
	`MDI2C_ASSERT_ALWAYS(a_reset_empty,
		!arst_n |=> !out_valid_q && !valid_s1, "pipeline not empty in reset")

endmodule

// ===== hw/rtl/mdi2c_target.sv =====
// ----------------------------------------------------------------------------
// mdi2c_target
// Bus target state machine: address match, object/value receive, status read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdi2c_target (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                start_seen,
	input  logic [7:0]          shift_byte,
	input  logic [6:0]          target_address,
	input  logic                motion_flag,
	output mdi2c_pkg::bus_res_t res,
	output logic                sda_level,
	output logic [7:0]          threshold
);

	mdi2c_pkg::bus_state_t state_q, st, state_nxt;
	logic [7:0] rx_object_q, rx_object_nxt;
	logic [7:0] rx_value_q, rx_value_nxt;
	logic [7:0] threshold_q, threshold_nxt;
	logic       sda_q, sda_nxt;

	always_comb begin
		// a start condition restarts at address receive
		st            = start_seen ? mdi2c_pkg::ST_RX_ADDR : state_q;
		state_nxt     = st;
		rx_object_nxt = rx_object_q;
		rx_value_nxt  = rx_value_q;
		threshold_nxt = threshold_q;
		sda_nxt       = sda_q;
		res.load      = 1'b0;
		res.data      = mdi2c_pkg::ACK_BYTE;
		res.count     = mdi2c_pkg::CNT_NONE;
		res.upd       = 1'b0;
		res.code      = '0;
		unique case (st)
			mdi2c_pkg::ST_RX_ADDR: begin
				res.count = mdi2c_pkg::CNT_BYTE;
				state_nxt = mdi2c_pkg::ST_CHK_ADDR;
			end
			mdi2c_pkg::ST_CHK_ADDR: begin
				sda_nxt   = 1'b1;
				res.load  = 1'b1;
				res.count = mdi2c_pkg::CNT_ACK;
				if (shift_byte == {target_address, shift_byte[0]}) begin
					res.data  = mdi2c_pkg::ACK_BYTE;
					state_nxt = shift_byte[0] ? mdi2c_pkg::ST_TX_DATA : mdi2c_pkg::ST_RX_OBJ;
				end else begin
					res.data  = mdi2c_pkg::NACK_BYTE;
					state_nxt = mdi2c_pkg::ST_WAIT;
				end
			end
			mdi2c_pkg::ST_WAIT: begin
				sda_nxt   = 1'b0;
				state_nxt = mdi2c_pkg::ST_IDLE;
			end
			mdi2c_pkg::ST_RX_OBJ: begin
				sda_nxt   = 1'b0;
				res.count = mdi2c_pkg::CNT_BYTE;
				state_nxt = mdi2c_pkg::ST_ACK_OBJ;
			end
			mdi2c_pkg::ST_ACK_OBJ: begin
				sda_nxt       = 1'b1;
				rx_object_nxt = shift_byte;
				res.load      = 1'b1;
				res.count     = mdi2c_pkg::CNT_ACK;
				state_nxt     = mdi2c_pkg::ST_RX_VAL;
			end
			mdi2c_pkg::ST_RX_VAL: begin
				sda_nxt   = 1'b0;
				res.count = mdi2c_pkg::CNT_BYTE;
				state_nxt = mdi2c_pkg::ST_ACK_VAL;
			end
			mdi2c_pkg::ST_ACK_VAL: begin
				sda_nxt      = 1'b1;
				rx_value_nxt = shift_byte;
				res.load     = 1'b1;
				res.count    = mdi2c_pkg::CNT_ACK;
				state_nxt    = mdi2c_pkg::ST_APPLY;
			end
			mdi2c_pkg::ST_APPLY: begin
				// other objects are ignored
				if (rx_object_q == mdi2c_pkg::OBJ_INTERVAL) begin
					res.upd  = 1'b1;
					res.code = rx_value_q[5:0] & mdi2c_pkg::CODE_MASK;
				end else if (rx_object_q == mdi2c_pkg::OBJ_THRESHOLD) begin
					threshold_nxt = rx_value_q;
				end
				state_nxt = mdi2c_pkg::ST_WAIT;
			end
			mdi2c_pkg::ST_TX_DATA: begin
				sda_nxt   = 1'b1;
				res.load  = 1'b1;
				res.data  = {7'd0, motion_flag};
				res.count = mdi2c_pkg::CNT_BYTE;
				state_nxt = mdi2c_pkg::ST_RX_ACK;
			end
			mdi2c_pkg::ST_RX_ACK: begin
				sda_nxt   = 1'b0;
				res.count = mdi2c_pkg::CNT_ACK;
				state_nxt = mdi2c_pkg::ST_CHK_ACK;
			end
			mdi2c_pkg::ST_CHK_ACK: begin
				// NACK from the controller releases the line
				if (shift_byte[0]) begin
					sda_nxt = 1'b0;
				end
				state_nxt = mdi2c_pkg::ST_WAIT;
			end
			default: begin
				// idle without start: nothing moves
			end
		endcase
		res.sda = sda_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mdi2c_pkg::ST_IDLE;
			rx_object_q <= '0;
			rx_value_q  <= '0;
			threshold_q <= mdi2c_pkg::THRESH_RESET;
			sda_q       <= 1'b0;
		end else if (step) begin
			state_q     <= state_nxt;
			rx_object_q <= rx_object_nxt;
			rx_value_q  <= rx_value_nxt;
			threshold_q <= threshold_nxt;
			sda_q       <= sda_nxt;
		end
	end

	assign sda_level = sda_q;
	assign threshold = threshold_q;

endmodule
